FILE: rtl/bb3_pkg.sv
package bb3_pkg;

	// Configuration registers are 12 bits wide whatever the frame limits are.
	localparam int CFG_BITS = 12;
	localparam int ROW_BITS = 12;
	localparam logic [ROW_BITS-1:0] ROW_SAT = 12'hFFF;

	localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 12'd1280;
	localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 12'd720;

	// Half of the kernel weight sum, so that the division by 36 rounds half up.
	localparam int ROUND_BIAS = 18;

	typedef enum logic [0:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic valid;
		logic emit;
		logic last;
		logic interior;
	} step_ctl_t;

	function automatic logic [ROW_BITS-1:0] row_inc(input logic [ROW_BITS-1:0] row);
		row_inc = (row == ROW_SAT) ? row : row + ROW_BITS'(1);
	endfunction

endpackage

FILE: rtl/bb3_if.sv
interface bb3_pix_in_if #(
	parameter int CB = 16
);
	logic          valid;
	logic          ready;
	logic [CB-1:0] red_in;
	logic [CB-1:0] green_in;
	logic [CB-1:0] blue_in;
	logic          is_padding;

	modport source (output valid, red_in, green_in, blue_in, is_padding, input ready);
	modport sink (input valid, red_in, green_in, blue_in, is_padding, output ready);
endinterface

interface bb3_pix_out_if #(
	parameter int CB = 16
);
	logic          valid;
	logic          ready;
	logic [CB-1:0] red_out;
	logic [CB-1:0] green_out;
	logic [CB-1:0] blue_out;
	logic          frame_last;

	modport source (output valid, red_out, green_out, blue_out, frame_last, input ready);
	modport sink (input valid, red_out, green_out, blue_out, frame_last, output ready);
endinterface

FILE: rtl/bb3_lstore.sv
module bb3_lstore #(
	parameter int DEPTH = 2048,
	parameter int PW    = 48
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     adv,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	input  logic [PW-1:0]            px,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	output logic [PW-1:0]            older,
	output logic [PW-1:0]            newer,
	output logic [PW-1:0]            px_s1
);

	// Each entry holds the two previous rows of one column: {row r-1, row r-2}.
	logic [2*PW-1:0] mem [DEPTH];
	logic [2*PW-1:0] rd_q;
	logic            fwd_s1;
	logic [PW-1:0]   fwd_new_s1;
	logic [PW-1:0]   fwd_old_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			rd_q <= mem[rd_addr];
			if (wr_en) begin
				mem[wr_addr] <= {px_s1, newer};
			end
		end
	end

	// A request reading the column that the request ahead of it writes in the
	// same cycle gets the old word from the array, so the new word is kept here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_s1 <= 1'b0;
		end else if (adv) begin
			fwd_s1 <= wr_en && (wr_addr == rd_addr);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s1      <= px;
			fwd_new_s1 <= px_s1;
			fwd_old_s1 <= newer;
		end
	end

	assign newer = fwd_s1 ? fwd_new_s1 : rd_q[2*PW-1:PW];
	assign older = fwd_s1 ? fwd_old_s1 : rd_q[PW-1:0];

endmodule

FILE: rtl/bb3_ctrl.sv
module bb3_ctrl #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  bb3_pkg::cfg_reg_t                cfg_index,
	input  logic [bb3_pkg::CFG_BITS-1:0]     cfg_data,
	input  logic                             adv,
	input  logic                             acc,
	output logic [$clog2(MAX_WIDTH)-1:0]     rd_addr,
	output logic [$clog2(MAX_WIDTH)-1:0]     col_s1,
	output bb3_pkg::step_ctl_t               ctl_s1
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int WB = $clog2(MAX_WIDTH + 1);
	localparam int HB = $clog2(MAX_HEIGHT + 1);
	localparam int TB = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
	localparam int RB = bb3_pkg::ROW_BITS;

	localparam int W_RST_I = (int'(bb3_pkg::WIDTH_RESET) > MAX_WIDTH) ?
		MAX_WIDTH : int'(bb3_pkg::WIDTH_RESET);
	localparam int H_RST_I = (int'(bb3_pkg::HEIGHT_RESET) > MAX_HEIGHT) ?
		MAX_HEIGHT : int'(bb3_pkg::HEIGHT_RESET);
	localparam logic [WB-1:0] W_RST = WB'(W_RST_I);
	localparam logic [HB-1:0] H_RST = HB'(H_RST_I);
	localparam logic [TB-1:0] T_RST = TB'(W_RST_I * H_RST_I);

	logic [WB-1:0] w_q;
	logic [HB-1:0] h_q;
	logic [TB-1:0] total_q;
	logic [WB-1:0] w_new;
	logic [HB-1:0] h_new;

	logic [AW-1:0] col_q;
	logic [RB-1:0] row_q;
	logic [TB-1:0] emitted_q;

	logic [AW-1:0] col_a;
	logic [RB-1:0] row_a;
	logic          emit_a;
	logic          last_a;
	logic [31:0]   col_inc;
	logic          wrap_post;
	logic [AW-1:0] col_n;
	logic [RB-1:0] row_n;
	logic [TB-1:0] emitted_n;

	logic          v_s1;
	logic          emit_s1;
	logic          last_s1;
	logic [RB-1:0] row_s1;
	logic [31:0]   cx;
	logic [31:0]   cy;
	logic          interior;

	// Dimensions are kept clamped, and the pixel count is formed at the write.
	always_comb begin
		if (cfg_data == '0) begin
			w_new = WB'(1);
			h_new = HB'(1);
		end else begin
			w_new = (32'(cfg_data) > 32'(MAX_WIDTH)) ? WB'(MAX_WIDTH) : WB'(cfg_data);
			h_new = (32'(cfg_data) > 32'(MAX_HEIGHT)) ? HB'(MAX_HEIGHT) : HB'(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q     <= W_RST;
			h_q     <= H_RST;
			total_q <= T_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				bb3_pkg::REG_FRAME_WIDTH: begin
					w_q     <= w_new;
					total_q <= TB'(w_new) * TB'(h_q);
				end
				bb3_pkg::REG_FRAME_HEIGHT: begin
					h_q     <= h_new;
					total_q <= TB'(w_q) * TB'(h_new);
				end
				default: begin
					w_q <= w_q;
				end
			endcase
		end
	end

	// Raster position of the request being taken. A column left at or past a
	// width lowered mid-frame starts a new row first.
	always_comb begin
		if (32'(col_q) >= 32'(w_q)) begin
			col_a = '0;
			row_a = bb3_pkg::row_inc(row_q);
		end else begin
			col_a = col_q;
			row_a = row_q;
		end
		emit_a    = (row_a >= RB'(2)) || ((row_a == RB'(1)) && (col_a != '0));
		last_a    = emit_a && ((32'(emitted_q) + 32'd1) >= 32'(total_q));
		col_inc   = 32'(col_a) + 32'd1;
		wrap_post = col_inc >= 32'(w_q);
		if (last_a) begin
			col_n     = '0;
			row_n     = '0;
			emitted_n = '0;
		end else begin
			col_n     = wrap_post ? '0 : AW'(col_inc);
			row_n     = wrap_post ? bb3_pkg::row_inc(row_a) : row_a;
			emitted_n = emit_a ? emitted_q + TB'(1) : emitted_q;
		end
	end

	assign rd_addr = col_a;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			emitted_q <= '0;
			v_s1      <= 1'b0;
		end else begin
			if (acc) begin
				col_q     <= col_n;
				row_q     <= row_n;
				emitted_q <= emitted_n;
			end
			if (adv) begin
				v_s1 <= acc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			col_s1  <= col_a;
			row_s1  <= row_a;
			emit_s1 <= emit_a;
			last_s1 <= last_a;
		end
	end

	// The pixel leaving the window centre lies one column back, or at the end
	// of the row before when the new request opens a row.
	always_comb begin
		if (col_s1 == '0) begin
			cx = 32'(w_q) - 32'd1;
			cy = 32'(row_s1) - 32'd2;
		end else begin
			cx = 32'(col_s1) - 32'd1;
			cy = 32'(row_s1) - 32'd1;
		end
		interior = (cx >= 32'd2) && ((cx + 32'd3) <= 32'(w_q)) &&
			(cy >= 32'd2) && ((cy + 32'd3) <= 32'(h_q));
	end

	assign ctl_s1 = '{valid: v_s1, emit: emit_s1, last: last_s1, interior: interior};

endmodule

FILE: rtl/bb3_filter.sv
module bb3_filter #(
	parameter int CB = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  bb3_pkg::step_ctl_t ctl,
	input  logic [3*CB-1:0]    col_top,
	input  logic [3*CB-1:0]    col_mid,
	input  logic [3*CB-1:0]    col_bot,
	output logic               res_valid,
	output logic [3*CB-1:0]    res_pix,
	output logic               res_last
);

	localparam int PW = 3 * CB;
	localparam int SW = CB + 6;
	localparam int XW = SW - 2;
	localparam int SH = XW + 3;
	// Division by 9 as a multiplication; exact for every value below 2**XW.
	localparam logic [63:0] RECIP_64 = ((64'd1 << SH) + 64'd8) / 64'd9;
	localparam logic [XW-1:0] RECIP = RECIP_64[XW-1:0];

	logic [PW-1:0] win_q [3][3];
	logic          v_s2, v_s3, v_s4;
	logic          last_s2, last_s3, last_s4;
	logic          int_s2, int_s3, int_s4;
	logic [PW-1:0] center_s3, center_s4;

	always_ff @(posedge clk) begin
		if (adv && ctl.valid) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= col_top;
			win_q[1][2] <= col_mid;
			win_q[2][2] <= col_bot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			res_valid <= 1'b0;
		end else if (adv) begin
			v_s2      <= ctl.valid && ctl.emit;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			res_valid <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s2   <= ctl.last;
			int_s2    <= ctl.interior;
			last_s3   <= last_s2;
			int_s3    <= int_s2;
			center_s3 <= win_q[1][1];
			last_s4   <= last_s3;
			int_s4    <= int_s3;
			center_s4 <= center_s3;
			res_last  <= last_s4;
		end
	end

	for (genvar ch = 0; ch < 3; ch++) begin : g_chan
		logic [SW-1:0]   tap [3][3];
		logic [SW-1:0]   top_s3, mid_s3, bot_s3;
		logic [SW-1:0]   sum_s4;
		logic [XW-1:0]   quarter;
		logic [2*XW-1:0] prod;

		always_comb begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					tap[r][c] = SW'(win_q[r][c][ch*CB +: CB]);
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				top_s3 <= tap[0][0] + (tap[0][1] << 2) + tap[0][2] + SW'(bb3_pkg::ROUND_BIAS);
				mid_s3 <= (tap[1][0] << 2) + (tap[1][1] << 4) + (tap[1][2] << 2);
				bot_s3 <= tap[2][0] + (tap[2][1] << 2) + tap[2][2];
				sum_s4 <= top_s3 + mid_s3 + bot_s3;
			end
		end

		// (sum + 18) / 36 as ((sum + 18) / 4) / 9.
		assign quarter = sum_s4[SW-1:2];
		assign prod    = quarter * RECIP;

		always_ff @(posedge clk) begin
			if (adv) begin
				res_pix[ch*CB +: CB] <= int_s4 ? prod[SH +: CB] : center_s4[ch*CB +: CB];
			end
		end
	end

endmodule

FILE: rtl/binomial_blur_3x3.sv
// Streaming 3x3 weighted blur for RGB video in raster order. Each pixel request
// carries three channels; every interior pixel is filtered per channel with the
// kernel [1 4 1; 4 16 4; 1 4 1]/36, rounded half up, while pixels within two of
// any frame edge pass through unchanged. The filter sees only unfiltered pixels.
// A frame of frame_width x frame_height pixels is followed by frame_width+1
// padding requests; the first frame_width+1 requests of a frame give no result
// and every later one gives exactly one, frame_last marking the frame's final
// pixel. One request is taken every clock cycle unless the output stalls; a
// result passes registers s1 to s4 before the output register. The two previous
// rows live in one line memory with a registered read, read and written once
// per cycle unless stalled (same-column accesses of adjacent requests are
// forwarded), and a stalled output holds the whole pipeline and drops ready in
// the same cycle. Dimension writes take effect at once but belong in the gaps
// between frames. The line memory needs no clearing after reset.
module binomial_blur_3x3 #(
	parameter int MAX_WIDTH    = 2048,
	parameter int MAX_HEIGHT   = 2048,
	parameter int CHANNEL_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	bb3_pix_in_if.sink                   pixel,
	bb3_pix_out_if.source                result,
	input  logic                         cfg_wr_en,
	input  bb3_pkg::cfg_reg_t            cfg_index,
	input  logic [bb3_pkg::CFG_BITS-1:0] cfg_data
);

	localparam int CB = CHANNEL_BITS;
	localparam int PW = 3 * CB;
	localparam int AW = $clog2(MAX_WIDTH);

	logic               adv;
	logic               acc;
	logic [PW-1:0]      px_new;
	logic [AW-1:0]      rd_addr;
	logic [AW-1:0]      col_s1;
	bb3_pkg::step_ctl_t ctl_s1;
	logic [PW-1:0]      older;
	logic [PW-1:0]      newer;
	logic [PW-1:0]      px_s1;
	logic               res_valid;
	logic [PW-1:0]      res_pix;
	logic               res_last;

	assign adv         = !res_valid || result.ready;
	assign pixel.ready = adv;
	assign acc         = pixel.valid && adv;
	assign px_new      = pixel.is_padding ? '0 :
		{pixel.red_in, pixel.green_in, pixel.blue_in};

	bb3_ctrl #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.adv       (adv),
		.acc       (acc),
		.rd_addr   (rd_addr),
		.col_s1    (col_s1),
		.ctl_s1    (ctl_s1)
	);

	bb3_lstore #(
		.DEPTH (MAX_WIDTH),
		.PW    (PW)
	) u_lstore (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.rd_addr (rd_addr),
		.px      (px_new),
		.wr_en   (ctl_s1.valid),
		.wr_addr (col_s1),
		.older   (older),
		.newer   (newer),
		.px_s1   (px_s1)
	);

	bb3_filter #(
		.CB (CB)
	) u_filter (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.ctl       (ctl_s1),
		.col_top   (older),
		.col_mid   (newer),
		.col_bot   (px_s1),
		.res_valid (res_valid),
		.res_pix   (res_pix),
		.res_last  (res_last)
	);

	assign result.valid      = res_valid;
	assign result.red_out    = res_pix[2*CB +: CB];
	assign result.green_out  = res_pix[CB +: CB];
	assign result.blue_out   = res_pix[0 +: CB];
	assign result.frame_last = res_last;

endmodule

FILE: rtl/bb3_checker.sv
module bb3_checker #(
	parameter int CB = 16
) (
	input logic          clk,
	input logic          arst_n,
	input logic          in_ready,
	input logic          out_valid,
	input logic          out_ready,
	input logic [3*CB:0] out_data
);

	// A result waiting at the output stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("result changed while stalled");

	// With the output register empty the pipeline must be moving.
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input held off with an empty output");

	// A stalled output freezes the pipeline, so nothing new may enter.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while the output is stalled");

endmodule

bind binomial_blur_3x3 bb3_checker #(
	.CB (CHANNEL_BITS)
) u_bb3_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (pixel.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_data  ({result.frame_last, result.red_out, result.green_out, result.blue_out})
);

FILE: tb/tb_binomial_blur_3x3.sv
module tb_binomial_blur_3x3;

	localparam int LINE_MAX = 2048;
	localparam int ROWS_MAX = 2048;
	localparam int CB = 16;
	localparam int KERNEL_SUM = 36;
	localparam int LONG_HOLD = 400;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS = 1000;
	localparam int DRAIN_LIMIT = 20000;

	// Channel 0 is red, 1 green, 2 blue.
	typedef logic [2:0][CB-1:0] rgb_t;
	typedef struct packed {
		rgb_t px;
		logic padding;
	} pixel_req_t;
	typedef struct packed {
		rgb_t px;
		logic last;
	} blurred_pixel_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	bb3_pkg::cfg_reg_t cfg_index;
	logic [bb3_pkg::CFG_BITS-1:0] cfg_data;

	bb3_pix_in_if #(.CB(CB)) pix_if ();
	bb3_pix_out_if #(.CB(CB)) res_if ();

	binomial_blur_3x3 #(
		.MAX_WIDTH(LINE_MAX),
		.MAX_HEIGHT(ROWS_MAX),
		.CHANNEL_BITS(CB)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.pixel(pix_if),
		.result(res_if),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Shadow of the block: dimensions, line stores, window and raster counters.
	logic [bb3_pkg::CFG_BITS-1:0] width_reg;
	logic [bb3_pkg::CFG_BITS-1:0] height_reg;
	rgb_t older_rows [LINE_MAX];
	rgb_t newer_rows [LINE_MAX];
	rgb_t window [3][3];
	int unsigned col_pos;
	int unsigned row_pos;
	int unsigned out_count;

	pixel_req_t pending_pixels [$];
	blurred_pixel_t expected_pixels [$];
	int unsigned requests_queued;
	int fault_count;
	logic calm;
	logic sender_hold;
	int hold_requests;
	int holds_seen;
	int send_gap;
	int stall_left;

	function automatic int unsigned dim_of(input logic [bb3_pkg::CFG_BITS-1:0] v,
		input int unsigned limit);
		if (v == '0)
			return 1;
		if (v > limit)
			return limit;
		return v;
	endfunction

	function automatic logic [CB-1:0] blur_channel(input int ch);
		int unsigned s;
		s = window[0][0][ch] + 4 * window[0][1][ch] + window[0][2][ch]
			+ 4 * window[1][0][ch] + 16 * window[1][1][ch] + 4 * window[1][2][ch]
			+ window[2][0][ch] + 4 * window[2][1][ch] + window[2][2][ch];
		return CB'((s + bb3_pkg::ROUND_BIAS) / KERNEL_SUM);
	endfunction

	task automatic blur_predict(input pixel_req_t req);
		int unsigned w;
		int unsigned h;
		int unsigned cx;
		int unsigned cy;
		rgb_t px;
		logic interior;
		logic frame_done;
		blurred_pixel_t res;
		w = dim_of(width_reg, LINE_MAX);
		h = dim_of(height_reg, ROWS_MAX);
		frame_done = 1'b0;
		// A column count left at or past a lowered width starts a new row.
		if (col_pos >= w) begin
			col_pos = 0;
			if (row_pos < bb3_pkg::ROW_SAT)
				row_pos++;
		end
		px = req.padding ? '0 : req.px;
		for (int r = 0; r < 3; r++) begin
			window[r][0] = window[r][1];
			window[r][1] = window[r][2];
		end
		window[0][2] = older_rows[col_pos];
		window[1][2] = newer_rows[col_pos];
		window[2][2] = px;
		older_rows[col_pos] = newer_rows[col_pos];
		newer_rows[col_pos] = px;
		if (row_pos >= 2 || (row_pos == 1 && col_pos >= 1)) begin
			if (col_pos == 0) begin
				cx = w - 1;
				cy = row_pos - 2;
			end else begin
				cx = col_pos - 1;
				cy = row_pos - 1;
			end
			interior = cx >= 2 && cx + 3 <= w && cy >= 2 && cy + 3 <= h;
			for (int ch = 0; ch < 3; ch++)
				res.px[ch] = interior ? blur_channel(ch) : window[1][1][ch];
			res.last = (out_count + 1 >= w * h);
			expected_pixels.push_back(res);
			if (res.last) begin
				out_count = 0;
				col_pos = 0;
				row_pos = 0;
				frame_done = 1'b1;
			end else begin
				out_count = (out_count + 1) & 32'h003F_FFFF;
			end
		end
		if (!frame_done) begin
			col_pos++;
			if (col_pos >= w) begin
				col_pos = 0;
				if (row_pos < bb3_pkg::ROW_SAT)
					row_pos++;
			end
		end
	endtask

	function automatic logic [CB-1:0] rand_channel();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return CB'($urandom);
		endcase
	endfunction

	function automatic rgb_t rand_rgb();
		rgb_t px;
		for (int ch = 0; ch < 3; ch++)
			px[ch] = rand_channel();
		return px;
	endfunction

	function automatic logic [bb3_pkg::CFG_BITS-1:0] pick_dim(input int unsigned lo,
		input int unsigned hi);
		case ($urandom_range(0, 9))
			0: return '0;
			1: return bb3_pkg::CFG_BITS'($urandom_range(1, lo - 1));
			default: return bb3_pkg::CFG_BITS'($urandom_range(lo, hi));
		endcase
	endfunction

	task automatic push_pixel(input rgb_t px, input logic padding);
		pixel_req_t req;
		req.px = px;
		req.padding = padding;
		pending_pixels.push_back(req);
		requests_queued++;
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_pixels.size() != 0 || expected_pixels.size() != 0);
		// A request that gives no result may still be in the pipeline.
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_dimension(input bb3_pkg::cfg_reg_t idx,
		input logic [bb3_pkg::CFG_BITS-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == bb3_pkg::REG_FRAME_WIDTH)
			width_reg = val;
		else
			height_reg = val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic set_frame(input logic [bb3_pkg::CFG_BITS-1:0] w_raw,
		input logic [bb3_pkg::CFG_BITS-1:0] h_raw);
		wait_idle();
		write_dimension(bb3_pkg::REG_FRAME_WIDTH, w_raw);
		write_dimension(bb3_pkg::REG_FRAME_HEIGHT, h_raw);
	endtask

	// A broken frame may be cut short; the next frame then starts mid-raster.
	task automatic send_frame(input int unsigned w, input int unsigned h, input bit broken);
		int unsigned count;
		int unsigned cut;
		int unsigned i;
		count = w * h + w + 1;
		cut = broken ? $urandom_range(1, count) : count;
		for (i = 0; i < cut; i++) begin
			if (i < w * h)
				push_pixel(rand_rgb(), $urandom_range(0, 39) == 0);
			else
				push_pixel(rand_rgb(), 1'b1);
		end
	endtask

	// Pads one request at a time until the shadow counters show a new frame.
	task automatic finish_frame();
		do
			@(negedge clk);
		while (pending_pixels.size() != 0);
		while (col_pos != 0 || row_pos != 0 || out_count != 0) begin
			push_pixel(rand_rgb(), 1'b1);
			do
				@(negedge clk);
			while (pending_pixels.size() != 0);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#3000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin : driver
		logic accepted;
		if (!arst_n) begin
			pix_if.valid <= 1'b0;
			send_gap = 0;
		end else begin
			accepted = pix_if.valid && pix_if.ready;
			if (accepted) begin
				blur_predict(pending_pixels[0]);
				void'(pending_pixels.pop_front());
			end
			if (pix_if.valid && !accepted) begin
				// The request on offer stays unchanged until it is taken.
			end else if (send_gap > 0) begin
				send_gap--;
				pix_if.valid <= 1'b0;
			end else if (sender_hold || pending_pixels.size() == 0) begin
				pix_if.valid <= 1'b0;
			end else if (!calm && $urandom_range(0, 15) == 0) begin
				send_gap = $urandom_range(1, 12) - 1;
				pix_if.valid <= 1'b0;
			end else begin
				pix_if.valid <= 1'b1;
				pix_if.red_in <= pending_pixels[0].px[0];
				pix_if.green_in <= pending_pixels[0].px[1];
				pix_if.blue_in <= pending_pixels[0].px[2];
				pix_if.is_padding <= pending_pixels[0].padding;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : monitor
		blurred_pixel_t want;
		if (!arst_n) begin
			res_if.ready <= 1'b0;
			stall_left = 0;
			holds_seen = 0;
		end else begin
			if (res_if.valid && res_if.ready) begin
				if (expected_pixels.size() == 0) begin
					fault_count++;
					if (fault_count <= 10)
						$display("unexpected result r=%h g=%h b=%h last=%b",
							res_if.red_out, res_if.green_out, res_if.blue_out,
							res_if.frame_last);
				end else begin
					want = expected_pixels.pop_front();
					if (res_if.red_out !== want.px[0] || res_if.green_out !== want.px[1]
						|| res_if.blue_out !== want.px[2]
						|| res_if.frame_last !== want.last) begin
						fault_count++;
						if (fault_count <= 10)
							$display({"mismatch: expected r=%h g=%h b=%h last=%b, ",
								"got r=%h g=%h b=%h last=%b"},
								want.px[0], want.px[1], want.px[2], want.last,
								res_if.red_out, res_if.green_out, res_if.blue_out,
								res_if.frame_last);
					end
				end
			end
			if (hold_requests != holds_seen) begin
				holds_seen = hold_requests;
				stall_left = LONG_HOLD;
			end
			if (stall_left > 0) begin
				stall_left--;
				res_if.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 15) == 0) begin
				stall_left = $urandom_range(1, 12) - 1;
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= 1'b1;
			end
		end
	end

	initial begin
		int unsigned start;
		int unsigned n;
		logic [bb3_pkg::CFG_BITS-1:0] w_raw;
		logic [bb3_pkg::CFG_BITS-1:0] h_raw;
		rgb_t px;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = bb3_pkg::REG_FRAME_WIDTH;
		cfg_data = '0;
		pix_if.valid = 1'b0;
		pix_if.red_in = '0;
		pix_if.green_in = '0;
		pix_if.blue_in = '0;
		pix_if.is_padding = 1'b0;
		res_if.ready = 1'b0;
		calm = 1'b0;
		sender_hold = 1'b0;
		hold_requests = 0;
		fault_count = 0;
		requests_queued = 0;
		width_reg = bb3_pkg::WIDTH_RESET;
		height_reg = bb3_pkg::HEIGHT_RESET;
		foreach (older_rows[i]) begin
			older_rows[i] = '0;
			newer_rows[i] = '0;
		end
		foreach (window[r, c])
			window[r][c] = '0;
		col_pos = 0;
		row_pos = 0;
		out_count = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Dimensions of zero act as one: a single full-scale pixel and its two pads.
		set_frame('0, '0);
		push_pixel('1, 1'b0);
		push_pixel(rand_rgb(), 1'b1);
		push_pixel(rand_rgb(), 1'b1);

		// The smallest frame with an interior pixel. Red is full scale everywhere;
		// one corner of the centre's neighbourhood sits exactly on and just below
		// a rounding half in green and blue; a padding flag lands on an edge pixel.
		set_frame(12'd5, 12'd5);
		for (int r = 0; r < 5; r++) begin
			for (int c = 0; c < 5; c++) begin
				px[0] = '1;
				px[1] = (r == 1 && c == 1) ? CB'(18) : '0;
				px[2] = (r == 1 && c == 1) ? CB'(17) : '0;
				push_pixel(px, r == 0 && c == 4);
			end
		end
		repeat (6) push_pixel(rand_rgb(), 1'b1);

		// Width lowered below the column count, then raised, before any result.
		set_frame(12'd6, 12'd6);
		repeat (4) push_pixel(rand_rgb(), 1'b0);
		wait_idle();
		write_dimension(bb3_pkg::REG_FRAME_WIDTH, 12'd3);
		finish_frame();
		set_frame(12'd6, 12'd6);
		repeat (3) push_pixel(rand_rgb(), 1'b0);
		wait_idle();
		write_dimension(bb3_pkg::REG_FRAME_WIDTH, 12'd9);
		finish_frame();

		// Both registers above their range, then brought down part way into a row.
		set_frame(12'hFFF, 12'hFFF);
		repeat (10) push_pixel(rand_rgb(), 1'b0);
		wait_idle();
		write_dimension(bb3_pkg::REG_FRAME_WIDTH, 12'd4);
		write_dimension(bb3_pkg::REG_FRAME_HEIGHT, 12'd1);
		finish_frame();

		// A wide single row and a tall single column.
		set_frame(12'd150, 12'd1);
		send_frame(150, 1, 1'b0);
		set_frame(12'd1, 12'd200);
		send_frame(1, 200, 1'b0);

		// Output held off long enough to back the pipeline up into the input,
		// then the sender stops until the output has drained completely.
		set_frame(12'd8, 12'd8);
		@(negedge clk);
		calm = 1'b1;
		send_frame(8, 8, 1'b0);
		hold_requests++;
		send_frame(8, 8, 1'b0);
		do
			@(negedge clk);
		while (pending_pixels.size() > 40);
		sender_hold = 1'b1;
		do
			@(negedge clk);
		while (pix_if.valid || expected_pixels.size() != 0);
		sender_hold = 1'b0;
		finish_frame();

		start = requests_queued;
		while (requests_queued - start < RANDOM_ITEMS) begin
			w_raw = pick_dim(4, 10);
			h_raw = pick_dim(5, 9);
			set_frame(w_raw, h_raw);
			@(negedge clk);
			calm = (requests_queued - start > RANDOM_ITEMS * 4 / 5)
				|| $urandom_range(0, 3) == 0;
			repeat ($urandom_range(1, 3))
				send_frame(dim_of(w_raw, LINE_MAX), dim_of(h_raw, ROWS_MAX),
					$urandom_range(0, 4) == 0);
			finish_frame();
		end

		do
			@(negedge clk);
		while (pending_pixels.size() != 0);
		for (n = 0; n < DRAIN_LIMIT && expected_pixels.size() != 0; n++)
			@(negedge clk);
		repeat (SETTLE_CYCLES * 4) @(negedge clk);
		if (expected_pixels.size() != 0) begin
			fault_count += expected_pixels.size();
			$display("%0d expected results never arrived", expected_pixels.size());
		end
		if (fault_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
